FILE: design/owtr_pkg.sv
package owtr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT     = 2'd3;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BUSY  = 3'd1;
  localparam logic [2:0] ST_CONV  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_NODEV = 3'd4;
  localparam logic [2:0] ST_READY = 3'd5;

  typedef struct packed {
    logic               drive_low;
    logic [2:0]         status;
    logic signed [15:0] temp_word;
    logic               device_present;
  } res_t;

endpackage

FILE: design/owtr_core.sv
module owtr_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             step_v,
  input  logic                             step_cmd,
  input  logic                             step_lvl,
  output owtr_pkg::res_t                   res
);
  import owtr_pkg::*;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_RST_LOW   = 4'd1;
  localparam logic [3:0] PH_RST_WAIT  = 4'd2;
  localparam logic [3:0] PH_RST_RECOV = 4'd3;
  localparam logic [3:0] PH_WR_LOW    = 4'd4;
  localparam logic [3:0] PH_WR_HIGH   = 4'd5;
  localparam logic [3:0] PH_RD_LOW    = 4'd6;
  localparam logic [3:0] PH_RD_WAIT   = 4'd7;
  localparam logic [3:0] PH_RD_REST   = 4'd8;

  localparam logic [7:0]  OP_SKIP_ROM = 8'hCC;
  localparam logic [7:0]  OP_CONVERT  = 8'h44;
  localparam logic [7:0]  OP_READ_PAD = 8'hBE;
  localparam logic [9:0]  T_WR1_LOW   = 10'd10;
  localparam logic [9:0]  T_WR0_LOW   = 10'd60;
  localparam logic [9:0]  T_WR1_HIGH  = 10'd50;
  localparam logic [9:0]  T_WR0_HIGH  = 10'd10;
  localparam logic [9:0]  T_RD_LOW    = 10'd2;
  localparam logic [9:0]  T_RD_SAMPLE = 10'd12;
  localparam logic [9:0]  T_RD_REST   = 10'd45;
  localparam logic [19:0] WAIT_MAX    = 20'hFFFFF;

  logic [9:0]  reset_low_r;
  logic [7:0]  presence_wait_r;
  logic [7:0]  recovery_r;
  logic [19:0] conv_wait_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [9:0]  timer_r, timer_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  cmd_shift_r, cmd_shift_nxt;
  logic [15:0] read_shift_r, read_shift_nxt;
  logic        presence_r, presence_nxt;
  logic        pending_r, pending_nxt;
  logic [19:0] wait_r, wait_nxt;
  logic [15:0] last_raw_r, last_raw_nxt;
  logic        present_r, present_nxt;
  logic        job_read_r, job_read_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= 10'd480;
      presence_wait_r <= 8'd60;
      recovery_r      <= 8'd100;
      conv_wait_r     <= 20'd750000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RESET_LOW:     reset_low_r     <= cfg_data[9:0];
        CFG_PRESENCE_WAIT: presence_wait_r <= cfg_data[7:0];
        CFG_RECOVERY:      recovery_r      <= cfg_data[7:0];
        CFG_CONV_WAIT:     conv_wait_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [4:0] bc_inc;
    logic [7:0] cs_w;
    logic       after_rec;
    bc_inc         = bit_count_r + 5'd1;
    cs_w           = {1'b0, cmd_shift_r[7:1]};
    after_rec      = 1'b0;
    phase_nxt      = phase_r;
    timer_nxt      = timer_r;
    bit_count_nxt  = bit_count_r;
    cmd_shift_nxt  = cmd_shift_r;
    read_shift_nxt = read_shift_r;
    presence_nxt   = presence_r;
    pending_nxt    = pending_r;
    wait_nxt       = wait_r;
    last_raw_nxt   = last_raw_r;
    present_nxt    = present_r;
    job_read_nxt   = job_read_r;
    res.status     = ST_IDLE;

    if (step_v) begin
      if (step_cmd == CMD_READ) begin
        if (phase_r != PH_IDLE) begin
          res.status = ST_BUSY;
        end else if (!pending_r) begin
          job_read_nxt = 1'b0;
          phase_nxt    = PH_RST_LOW;
          timer_nxt    = reset_low_r;
          res.status   = ST_BUSY;
        end else if (wait_r < conv_wait_r) begin
          res.status = ST_WAIT;
        end else begin
          job_read_nxt = 1'b1;
          phase_nxt    = PH_RST_LOW;
          timer_nxt    = reset_low_r;
          res.status   = ST_BUSY;
        end
      end else begin
        if (pending_r && wait_r != WAIT_MAX) wait_nxt = wait_r + 20'd1;
        if (phase_r == PH_IDLE) begin
          res.status = ST_IDLE;
        end else if (timer_r > 10'd1) begin
          timer_nxt  = timer_r - 10'd1;
          res.status = ST_BUSY;
        end else begin
          res.status = ST_BUSY;
          unique case (phase_r)
            PH_RST_LOW: begin
              phase_nxt = PH_RST_WAIT;
              timer_nxt = {2'b00, presence_wait_r};
            end
            PH_RST_WAIT: begin
              presence_nxt = step_lvl;
              present_nxt  = ~step_lvl;
              if (recovery_r == 8'd0) begin
                after_rec = 1'b1;
              end else begin
                phase_nxt = PH_RST_RECOV;
                timer_nxt = {2'b00, recovery_r};
              end
            end
            PH_RST_RECOV: after_rec = 1'b1;
            PH_WR_LOW: begin
              phase_nxt = PH_WR_HIGH;
              timer_nxt = cmd_shift_r[0] ? T_WR1_HIGH : T_WR0_HIGH;
            end
            PH_WR_HIGH: begin
              if (bc_inc == 5'd8) cs_w = job_read_r ? OP_READ_PAD : OP_CONVERT;
              cmd_shift_nxt = cs_w;
              bit_count_nxt = bc_inc;
              if (bc_inc >= 5'd16) begin
                if (!job_read_r) begin
                  pending_nxt = 1'b1;
                  wait_nxt    = 20'd0;
                  phase_nxt   = PH_IDLE;
                  timer_nxt   = 10'd0;
                  res.status  = ST_CONV;
                end else begin
                  bit_count_nxt  = 5'd0;
                  read_shift_nxt = 16'd0;
                  phase_nxt      = PH_RD_LOW;
                  timer_nxt      = T_RD_LOW;
                end
              end else begin
                phase_nxt = PH_WR_LOW;
                timer_nxt = cs_w[0] ? T_WR1_LOW : T_WR0_LOW;
              end
            end
            PH_RD_LOW: begin
              phase_nxt = PH_RD_WAIT;
              timer_nxt = T_RD_SAMPLE;
            end
            PH_RD_WAIT: begin
              read_shift_nxt = read_shift_r | ({15'd0, step_lvl} << bit_count_r[3:0]);
              phase_nxt      = PH_RD_REST;
              timer_nxt      = T_RD_REST;
            end
            PH_RD_REST: begin
              bit_count_nxt = bc_inc;
              if (bc_inc >= 5'd16) begin
                last_raw_nxt = read_shift_r;
                pending_nxt  = 1'b0;
                wait_nxt     = 20'd0;
                phase_nxt    = PH_IDLE;
                timer_nxt    = 10'd0;
                res.status   = ST_READY;
              end else begin
                phase_nxt = PH_RD_LOW;
                timer_nxt = T_RD_LOW;
              end
            end
            default: begin
              phase_nxt  = PH_IDLE;
              timer_nxt  = 10'd0;
              res.status = ST_IDLE;
            end
          endcase
          // presence line high means nobody answered
          if (after_rec) begin
            if (presence_nxt) begin
              phase_nxt  = PH_IDLE;
              timer_nxt  = 10'd0;
              res.status = ST_NODEV;
            end else begin
              cmd_shift_nxt = OP_SKIP_ROM;
              bit_count_nxt = 5'd0;
              phase_nxt     = PH_WR_LOW;
              timer_nxt     = OP_SKIP_ROM[0] ? T_WR1_LOW : T_WR0_LOW;
            end
          end
        end
      end
    end

    res.drive_low      = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                         (phase_nxt == PH_RD_LOW);
    res.temp_word      = last_raw_nxt;
    res.device_present = present_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      timer_r      <= 10'd0;
      bit_count_r  <= 5'd0;
      cmd_shift_r  <= 8'd0;
      read_shift_r <= 16'd0;
      presence_r   <= 1'b1;
      pending_r    <= 1'b0;
      wait_r       <= 20'd0;
      last_raw_r   <= 16'd0;
      present_r    <= 1'b0;
      job_read_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      timer_r      <= timer_nxt;
      bit_count_r  <= bit_count_nxt;
      cmd_shift_r  <= cmd_shift_nxt;
      read_shift_r <= read_shift_nxt;
      presence_r   <= presence_nxt;
      pending_r    <= pending_nxt;
      wait_r       <= wait_nxt;
      last_raw_r   <= last_raw_nxt;
      present_r    <= present_nxt;
      job_read_r   <= job_read_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_conv_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step_v && res.status == ST_CONV |=> pending_r && wait_r == 20'd0)
    else $error("conversion start did not mark pending");
  a_drive_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_v && res.drive_low |-> res.status == ST_BUSY)
    else $error("line driven low outside a busy beat");
  a_ready_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_v && res.status == ST_READY |=> !pending_r && wait_r == 20'd0 &&
    phase_r == PH_IDLE)
    else $error("read completion left stale state");
  a_idle_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE && !step_v |=> phase_r == PH_IDLE)
    else $error("sequencer left idle without a beat");
`endif

endmodule

FILE: design/owtr_out_buf.sv
module owtr_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  owtr_pkg::res_t push_data,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_stall,
  output owtr_pkg::res_t out_data
);
  import owtr_pkg::*;

  logic [1:0] count_r;
  res_t       head_r;
  res_t       tail_r;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign can_push  = (count_r != 2'd2) || pop;
  assign out_data  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      case (count_r)
        2'd0: if (push) count_r <= 2'd1;
        2'd1: begin
          if (push && !pop) count_r <= 2'd2;
          else if (!push && pop) count_r <= 2'd0;
        end
        default: if (pop && !push) count_r <= 2'd1;
      endcase
    end
  end

  // head always holds the oldest beat; tail only when two are waiting
  always_ff @(posedge clk) begin
    case (count_r)
      2'd0: if (push) head_r <= push_data;
      2'd1: begin
        if (push && pop) head_r <= push_data;
        else if (push) tail_r <= push_data;
      end
      default: begin
        if (pop) begin
          head_r <= tail_r;
          if (push) tail_r <= push_data;
        end
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("push into a full result buffer");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 && out_stall |=> count_r == 2'd2)
    else $error("full buffer lost a beat while stalled");
`endif

endmodule

FILE: design/onewire_temp_sensor_reader_top.sv
// Flow: an accepted beat is held in the input register, stepped through the sequencer
//   and written into the result buffer, whose head is offered on out_*.
// Throughput: one beat per cycle while the result buffer can take it; the sequencer
//   handles a beat in the cycle it is pushed, and the two-entry result buffer keeps input flowing while a result waits.
// Reset: synchronous active-low rst_n restores the register defaults, idles the
//   sequencer and empties the input register and result buffer.
module onewire_temp_sensor_reader_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic                             in_bus_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_drive_low,
  output logic [2:0]                       out_status,
  output logic signed [15:0]               out_temp_word,
  output logic                             out_device_present
);
  import owtr_pkg::*;

  logic in_v_r;
  logic in_cmd_r;
  logic in_lvl_r;
  logic can_push;
  logic push;
  res_t step_res;
  res_t out_res;

  assign push     = in_v_r && can_push;
  assign in_stall = in_v_r && !can_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (push) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd_r <= in_cmd;
      in_lvl_r <= in_bus_level;
    end
  end

  owtr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .step_v   (push),
    .step_cmd (in_cmd_r),
    .step_lvl (in_lvl_r),
    .res      (step_res)
  );

  owtr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (step_res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_drive_low      = out_res.drive_low;
  assign out_status         = out_res.status;
  assign out_temp_word      = out_res.temp_word;
  assign out_device_present = out_res.device_present;

`ifndef NO_ASSERTIONS
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no result backlog");
  a_held_beat_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_v_r)
    else $error("held input beat dropped");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_READY)
    else $error("undefined status code");
`endif

endmodule

FILE: verif/onewire_temp_sensor_reader_top_tb.sv
module onewire_temp_sensor_reader_top_tb;
  import owtr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [19:0] WAIT_SAT = 20'hFFFFF;
  localparam logic [7:0]  OW_SKIP_ROM     = 8'hCC;
  localparam logic [7:0]  OW_CONVERT      = 8'h44;
  localparam logic [7:0]  OW_READ_SCRATCH = 8'hBE;
  localparam logic [9:0]  W1_LOW_US    = 10'd10;
  localparam logic [9:0]  W1_REL_US    = 10'd50;
  localparam logic [9:0]  W0_LOW_US    = 10'd60;
  localparam logic [9:0]  W0_REL_US    = 10'd10;
  localparam logic [9:0]  RD_LOW_US    = 10'd2;
  localparam logic [9:0]  RD_SAMPLE_US = 10'd12;
  localparam logic [9:0]  RD_REST_US   = 10'd45;
  localparam int HOLD_AT_BEAT = 600;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_RECOV,
    SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_REST
  } seq_phase_t;

  typedef enum {DEV_PRESENT, DEV_ABSENT, DEV_FLAKY} device_mode_t;

  typedef struct packed {
    logic cmd;
    logic lvl;
    logic fixed;
    res_t want;
  } dir_row_t;

  localparam int DIR_N = 16;
  // Default settings: a request loads the 480 us reset pulse.
  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    '{CMD_TICK, 1'b0, 1'b1, '{1'b0, ST_IDLE, 16'sd0, 1'b0}},
    '{CMD_TICK, 1'b1, 1'b1, '{1'b0, ST_IDLE, 16'sd0, 1'b0}},
    '{CMD_READ, 1'b0, 1'b1, '{1'b1, ST_BUSY, 16'sd0, 1'b0}},
    '{CMD_READ, 1'b1, 1'b1, '{1'b1, ST_BUSY, 16'sd0, 1'b0}},
    '{CMD_TICK, 1'b1, 1'b1, '{1'b1, ST_BUSY, 16'sd0, 1'b0}},
    '{CMD_TICK, 1'b0, 1'b1, '{1'b1, ST_BUSY, 16'sd0, 1'b0}},
    '{CMD_READ, 1'b0, 1'b1, '{1'b1, ST_BUSY, 16'sd0, 1'b0}},
    '{CMD_TICK, 1'b1, 1'b0, '0},
    '{CMD_TICK, 1'b0, 1'b0, '0},
    '{CMD_READ, 1'b1, 1'b0, '0},
    '{CMD_TICK, 1'b1, 1'b0, '0},
    '{CMD_TICK, 1'b1, 1'b0, '0},
    '{CMD_TICK, 1'b0, 1'b0, '0},
    '{CMD_TICK, 1'b0, 1'b0, '0},
    '{CMD_READ, 1'b0, 1'b0, '0},
    '{CMD_TICK, 1'b1, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic                  in_bus_level;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_drive_low;
  logic [2:0]            out_status;
  logic signed [15:0]    out_temp_word;
  logic                  out_device_present;

  onewire_temp_sensor_reader_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_bus_level      (in_bus_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_low     (out_drive_low),
    .out_status        (out_status),
    .out_temp_word     (out_temp_word),
    .out_device_present(out_device_present)
  );

  // Sensor bus master mirror: settings and sequencer state.
  logic [9:0]  m_reset_low;
  logic [7:0]  m_presence_wait;
  logic [7:0]  m_recovery;
  logic [19:0] m_conv_wait;
  seq_phase_t  seq_phase;
  logic [9:0]  slot_cnt;
  logic [4:0]  bit_idx;
  logic [7:0]  cmd_byte;
  logic [15:0] rx_word;
  logic        presence_lvl;
  logic        conv_pending;
  logic [19:0] wait_cnt;
  logic [15:0] raw_temp;
  logic        dev_present;
  logic        job_read;

  res_t expected_readings[$];
  int   beats_in;
  int   mismatches;
  int   burst_left;
  int unsigned cycles;

  function automatic void clear_mirror();
    m_reset_low     = 10'd480;
    m_presence_wait = 8'd60;
    m_recovery      = 8'd100;
    m_conv_wait     = 20'd750000;
    seq_phase    = SEQ_IDLE;
    slot_cnt     = '0;
    bit_idx      = '0;
    cmd_byte     = '0;
    rx_word      = '0;
    presence_lvl = 1'b1;
    conv_pending = 1'b0;
    wait_cnt     = '0;
    raw_temp     = '0;
    dev_present  = 1'b0;
    job_read     = 1'b0;
  endfunction

  function automatic void enter_phase(seq_phase_t p, logic [9:0] ticks);
    seq_phase = p;
    slot_cnt  = ticks;
  endfunction

  function automatic void next_write_slot();
    enter_phase(SEQ_WR_LOW, cmd_byte[0] ? W1_LOW_US : W0_LOW_US);
  endfunction

  function automatic logic [2:0] finish_reset();
    if (presence_lvl) begin
      enter_phase(SEQ_IDLE, '0);
      return ST_NODEV;
    end
    cmd_byte = OW_SKIP_ROM;
    bit_idx  = '0;
    next_write_slot();
    return ST_BUSY;
  endfunction

  function automatic logic [2:0] seq_tick(logic lvl);
    if (slot_cnt > 1) begin
      slot_cnt--;
      return ST_BUSY;
    end
    case (seq_phase)
      SEQ_RST_LOW: begin
        enter_phase(SEQ_RST_WAIT, 10'(m_presence_wait));
        return ST_BUSY;
      end
      SEQ_RST_WAIT: begin
        presence_lvl = lvl;
        dev_present  = ~lvl;
        if (m_recovery == 0) return finish_reset();
        enter_phase(SEQ_RST_RECOV, 10'(m_recovery));
        return ST_BUSY;
      end
      SEQ_RST_RECOV: return finish_reset();
      SEQ_WR_LOW: begin
        enter_phase(SEQ_WR_HIGH, cmd_byte[0] ? W1_REL_US : W0_REL_US);
        return ST_BUSY;
      end
      SEQ_WR_HIGH: begin
        cmd_byte = cmd_byte >> 1;
        bit_idx++;
        // Second byte follows skip-ROM
        if (bit_idx == 8) cmd_byte = job_read ? OW_READ_SCRATCH : OW_CONVERT;
        if (bit_idx >= 16) begin
          if (!job_read) begin
            conv_pending = 1'b1;
            wait_cnt     = '0;
            enter_phase(SEQ_IDLE, '0);
            return ST_CONV;
          end
          bit_idx = '0;
          rx_word = '0;
          enter_phase(SEQ_RD_LOW, RD_LOW_US);
          return ST_BUSY;
        end
        next_write_slot();
        return ST_BUSY;
      end
      SEQ_RD_LOW: begin
        enter_phase(SEQ_RD_WAIT, RD_SAMPLE_US);
        return ST_BUSY;
      end
      SEQ_RD_WAIT: begin
        if (lvl) rx_word[bit_idx[3:0]] = 1'b1;
        enter_phase(SEQ_RD_REST, RD_REST_US);
        return ST_BUSY;
      end
      SEQ_RD_REST: begin
        bit_idx++;
        if (bit_idx >= 16) begin
          raw_temp     = rx_word;
          conv_pending = 1'b0;
          wait_cnt     = '0;
          enter_phase(SEQ_IDLE, '0);
          return ST_READY;
        end
        enter_phase(SEQ_RD_LOW, RD_LOW_US);
        return ST_BUSY;
      end
      default: begin
        enter_phase(SEQ_IDLE, '0);
        return ST_IDLE;
      end
    endcase
  endfunction

  function automatic res_t predict_reading(logic c, logic lvl);
    res_t r;
    logic [2:0] st;
    if (c == CMD_READ) begin
      if (seq_phase != SEQ_IDLE) begin
        st = ST_BUSY;
      end else if (!conv_pending) begin
        job_read = 1'b0;
        enter_phase(SEQ_RST_LOW, m_reset_low);
        st = ST_BUSY;
      end else if (wait_cnt < m_conv_wait) begin
        st = ST_WAIT;
      end else begin
        job_read = 1'b1;
        enter_phase(SEQ_RST_LOW, m_reset_low);
        st = ST_BUSY;
      end
    end else begin
      if (conv_pending && wait_cnt != WAIT_SAT) wait_cnt++;
      st = (seq_phase == SEQ_IDLE) ? ST_IDLE : seq_tick(lvl);
    end
    r.drive_low      = (seq_phase == SEQ_RST_LOW || seq_phase == SEQ_WR_LOW ||
                        seq_phase == SEQ_RD_LOW);
    r.status         = st;
    r.temp_word      = raw_temp;
    r.device_present = dev_present;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold one beat until taken, then mirror it.
  task automatic offer(input logic c, input logic lvl, input logic fixed, input res_t want);
    res_t r;
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_bus_level <= lvl;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = predict_reading(c, lvl);
    expected_readings.push_back(fixed ? want : r);
    beats_in++;
    @(negedge clk);
  endtask

  // Sender bursts: drop valid for a few cycles when a burst runs out.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                : $urandom_range(1, 40);
    end
  endtask

  task automatic load_settings(input logic [9:0] rl, input logic [7:0] pw,
                               input logic [7:0] rc, input logic [19:0] cw);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RESET_LOW;
    cfg_data <= CFG_DATA_W'(rl);
    @(negedge clk);
    cfg_idx  <= CFG_PRESENCE_WAIT;
    cfg_data <= CFG_DATA_W'(pw);
    @(negedge clk);
    cfg_idx  <= CFG_RECOVERY;
    cfg_data <= CFG_DATA_W'(rc);
    @(negedge clk);
    cfg_idx  <= CFG_CONV_WAIT;
    cfg_data <= cw;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_reset_low     = rl;
    m_presence_wait = pw;
    m_recovery      = rc;
    m_conv_wait     = cw;
  endtask

  task automatic run_phase(input int n_items, input device_mode_t dev);
    logic        c;
    logic        lvl;
    logic [15:0] temp_pat;
    temp_pat = '0;
    for (int i = 0; i < n_items; i++) begin
      if (seq_phase == SEQ_IDLE) begin
        // Pick the word the sensor will return on the next read
        case ($urandom_range(0, 4))
          0:       temp_pat = 16'h8000;
          1:       temp_pat = 16'h7FFF;
          2:       temp_pat = 16'h0000;
          3:       temp_pat = 16'hFFFF;
          default: temp_pat = 16'($urandom);
        endcase
        c = ($urandom_range(0, 15) == 0) ? CMD_READ : CMD_TICK;
      end else begin
        c = ($urandom_range(0, 299) == 0) ? CMD_READ : CMD_TICK;
      end
      case (seq_phase)
        SEQ_RST_WAIT: begin
          case (dev)
            DEV_PRESENT: lvl = ($urandom_range(0, 19) == 0);
            DEV_ABSENT:  lvl = ($urandom_range(0, 19) != 0);
            default:     lvl = $urandom_range(0, 1);
          endcase
        end
        SEQ_RD_WAIT: lvl = temp_pat[bit_idx[3:0]];
        default:     lvl = $urandom_range(0, 1);
      endcase
      pace();
      offer(c, lvl, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_drive_low, out_status, out_temp_word, out_device_present};
      if (expected_readings.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: drive_low=%0b status=%0d temp_word=%0d present=%0b",
                   got.drive_low, got.status, got.temp_word, got.device_present);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display({"reading mismatch: expected drive_low=%0b status=%0d temp_word=%0d ",
                      "present=%0b, got drive_low=%0b status=%0d temp_word=%0d present=%0b"},
                     want.drive_low, want.status, want.temp_word, want.device_present,
                     got.drive_low, got.status, got.temp_word, got.device_present);
          mismatches++;
        end
      end
    end
  end

  // Receiver: stall pattern changes at random intervals, plus one long hold.
  initial begin : rx_pace
    int mode;
    int left;
    bit held;
    mode = 0;
    left = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held && beats_in >= HOLD_AT_BEAT) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 256);
      end
      left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= (left % 4 == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : stim
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_RESET_LOW;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_cmd       <= CMD_TICK;
    in_bus_level <= 1'b0;
    beats_in   = 0;
    mismatches = 0;
    burst_left = 0;
    cycles     = 0;
    clear_mirror();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < DIR_N; k++) begin
      pace();
      offer(DIR_ROWS[k].cmd, DIR_ROWS[k].lvl, DIR_ROWS[k].fixed, DIR_ROWS[k].want);
    end

    // Shortest timings, no recovery, read allowed one tick after convert
    load_settings(10'd1, 8'd1, 8'd0, 20'd1);
    run_phase(400, DEV_PRESENT);
    load_settings(10'd5, 8'd3, 8'd2, 20'd40);
    run_phase(200, DEV_PRESENT);
    // Zero reset and presence settings
    load_settings(10'd0, 8'd0, 8'd1, 20'd200);
    run_phase(150, DEV_FLAKY);
    // Longest timings; the conversion wait never runs out here
    load_settings(10'd1023, 8'd255, 8'd255, 20'hFFFFF);
    run_phase(80, DEV_PRESENT);
    load_settings(10'd3, 8'd2, 8'd0, 20'd10);
    run_phase(120, DEV_ABSENT);
    load_settings(10'd20, 8'd10, 8'd5, 20'd100);
    run_phase(134, DEV_PRESENT);

    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/owtr_pkg.sv
design/owtr_core.sv
design/owtr_out_buf.sv
design/onewire_temp_sensor_reader_top.sv
verif/onewire_temp_sensor_reader_top_tb.sv
